/* hdl/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_SAME(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* hdl/uirf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package uirf_pkg;

  // frame offsets, in bytes from the first destination MAC byte
  localparam int POS_ETYPE_HI  = 12;
  localparam int POS_ETYPE_LO  = 13;
  localparam int POS_VERSION   = 14;
  localparam int POS_PROTOCOL  = 23;
  localparam int POS_SRC_IP0   = 26;
  localparam int POS_SRC_IP1   = 27;
  localparam int POS_SRC_IP2   = 28;
  localparam int POS_SRC_IP3   = 29;
  localparam int POS_SPORT_HI  = 34;
  localparam int POS_SPORT_LO  = 35;
  localparam int POS_DPORT_HI  = 36;
  localparam int POS_DPORT_LO  = 37;
  localparam int POS_ULEN_HI   = 38;
  localparam int POS_ULEN_LO   = 39;
  localparam int PAYLOAD_START = 14 + 20 + 8;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  VERSION_MASK   = 8'hF0;
  localparam logic [7:0]  VERSION_IPV4   = 8'h40;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;
  localparam logic [15:0] UDP_HDR_BYTES  = 16'd8;

  // result queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef enum logic [0:0] {
    REG_LISTEN_PORT = 1'b0,
    REG_MAX_PAYLOAD = 1'b1
  } cfg_reg_t;

  typedef enum logic [0:0] {
    KIND_PAYLOAD = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    RSN_OK        = 3'd0,
    RSN_SHORT     = 3'd1,
    RSN_NOT_IPV4  = 3'd2,
    RSN_BAD_VER   = 3'd3,
    RSN_NOT_UDP   = 3'd4,
    RSN_PORT_MISS = 3'd5
  } reason_t;

  typedef struct packed {
    kind_t        kind;
    logic [7:0]   data_byte;
    logic         accepted;
    reason_t      reason;
    logic [31:0]  src_ip;
    logic [15:0]  udp_sport;
    logic [15:0]  payload_len;
    logic         last;
  } result_t;

endpackage

`default_nettype wire

/* hdl/udp_ipv4_receive_filter.sv */
// UDP/IPv4 receive filter.
// Frame channel: frame_byte/frame_last arrive one byte per item, wire order,
//   taken when frame_valid is high and frame_stall is low.
// Result channel: one result item per handshake (result_valid, result_stall).
//   kind=0 carries a payload byte of an accepted frame; kind=1 is the
//   end-of-frame summary (accepted flag, reason, source IP/port, length).
// Config: cfg_write with cfg_addr 0 = listen port, 1 = max payload length.
// Path: a taken byte sits in the input register and is parsed from there once
//   the queue has room; its results join the queue that feeds the result port.
// Throughput: one byte per cycle while the queue has room. A frame's last
//   byte with payload owed yields two results; the 4-entry queue holds
//   the extra one until a result-free byte, so input never waits on it.
// Parsing advances only when the queue has room for two results; while the
//   receiver stalls, the queue fills and frame_stall rises once the input
//   register holds a byte that cannot be parsed.
// Reset clears the queue, the frame state and the config registers (listen
//   port 0, max payload 65535). After each summary the frame state clears.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module udp_ipv4_receive_filter #(
  parameter int MAX_FRAME_BYTES = 2048
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic        cfg_addr,
  input  wire logic [15:0] cfg_data,
  input  wire logic        frame_valid,
  output      logic        frame_stall,
  input  wire logic [7:0]  frame_byte,
  input  wire logic        frame_last,
  output      logic        result_valid,
  input  wire logic        result_stall,
  output      logic        kind,
  output      logic [7:0]  data_byte,
  output      logic        accepted,
  output      logic [2:0]  reason,
  output      logic [31:0] src_ip,
  output      logic [15:0] udp_sport,
  output      logic [15:0] payload_len,
  output      logic        last
);

  localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_FRAME_BYTES);

  // config
  logic [15:0] listen_port;
  logic [15:0] max_payload;

  // input register
  logic       s_valid;
  logic [7:0] s_byte;
  logic       s_last;

  // frame state
  logic [POS_W-1:0]       pos;
  uirf_pkg::reason_t      reject;
  logic [31:0]            src_addr;
  logic [15:0]            sport_seen;
  logic [15:0]            scratch;
  logic [15:0]            pay_left;

  logic [POS_W-1:0]       pos_next;
  uirf_pkg::reason_t      reject_next;
  logic [31:0]            src_addr_next;
  logic [15:0]            sport_seen_next;
  logic [15:0]            scratch_next;
  logic [15:0]            pay_left_next;

  // result queue
  uirf_pkg::result_t             q_mem [uirf_pkg::QDEPTH];
  logic [uirf_pkg::QPTR_W-1:0]   q_head;
  logic [uirf_pkg::QPTR_W-1:0]   q_tail;
  logic [uirf_pkg::QCNT_W-1:0]   q_count;
  logic [uirf_pkg::QCNT_W-1:0]   q_count_next;

  logic fire;
  logic take_in;
  logic pop;
  logic emit_pay;
  logic [15:0] word;
  logic [15:0] plen;
  uirf_pkg::reason_t  why;
  uirf_pkg::result_t  r_pay;
  uirf_pkg::result_t  r_sum;
  uirf_pkg::result_t  slot0;
  uirf_pkg::result_t  slot1;
  logic [1:0] push_n;
  uirf_pkg::result_t  head;
  logic head_pay;

  // parse only when two queue slots are free
  assign fire        = s_valid && (q_count <= uirf_pkg::QCNT_W'(uirf_pkg::QDEPTH - 2));
  assign frame_stall = s_valid && !fire;
  assign take_in     = frame_valid && !frame_stall;
  assign pop         = result_valid && !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      listen_port <= 16'd0;
      max_payload <= 16'hFFFF;
    end else if (cfg_write) begin
      unique case (cfg_addr)
        uirf_pkg::REG_LISTEN_PORT: listen_port <= cfg_data;
        uirf_pkg::REG_MAX_PAYLOAD: max_payload <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (take_in) begin
      s_valid <= 1'b1;
    end else if (fire) begin
      s_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      s_byte <= frame_byte;
      s_last <= frame_last;
    end
  end

  // header parse for the byte in the input register
  always_comb begin
    word            = scratch | {8'd0, s_byte};
    plen            = word - uirf_pkg::UDP_HDR_BYTES;
    reject_next     = reject;
    src_addr_next   = src_addr;
    sport_seen_next = sport_seen;
    scratch_next    = scratch;
    pay_left_next   = pay_left;
    if (plen > max_payload) begin
      plen = max_payload;
    end
    case (pos) inside
      POS_W'(uirf_pkg::POS_ETYPE_HI), POS_W'(uirf_pkg::POS_SPORT_HI),
      POS_W'(uirf_pkg::POS_DPORT_HI), POS_W'(uirf_pkg::POS_ULEN_HI): begin
        scratch_next = {s_byte, 8'd0};
      end
      POS_W'(uirf_pkg::POS_ETYPE_LO): begin
        if (word != uirf_pkg::ETHERTYPE_IPV4 && reject == uirf_pkg::RSN_OK) begin
          reject_next = uirf_pkg::RSN_NOT_IPV4;
        end
      end
      POS_W'(uirf_pkg::POS_VERSION): begin
        if ((s_byte & uirf_pkg::VERSION_MASK) != uirf_pkg::VERSION_IPV4 &&
            reject == uirf_pkg::RSN_OK) begin
          reject_next = uirf_pkg::RSN_BAD_VER;
        end
      end
      POS_W'(uirf_pkg::POS_PROTOCOL): begin
        if (s_byte != uirf_pkg::PROTO_UDP && reject == uirf_pkg::RSN_OK) begin
          reject_next = uirf_pkg::RSN_NOT_UDP;
        end
      end
      POS_W'(uirf_pkg::POS_SRC_IP0), POS_W'(uirf_pkg::POS_SRC_IP1),
      POS_W'(uirf_pkg::POS_SRC_IP2), POS_W'(uirf_pkg::POS_SRC_IP3): begin
        src_addr_next = {src_addr[23:0], s_byte};
      end
      POS_W'(uirf_pkg::POS_SPORT_LO): begin
        sport_seen_next = word;
      end
      POS_W'(uirf_pkg::POS_DPORT_LO): begin
        if (word != listen_port && reject == uirf_pkg::RSN_OK) begin
          reject_next = uirf_pkg::RSN_PORT_MISS;
        end
      end
      POS_W'(uirf_pkg::POS_ULEN_LO): begin
        // scratch now holds the clamped payload length
        scratch_next  = plen;
        pay_left_next = plen;
      end
      default: ;
    endcase

    emit_pay = (pos >= POS_W'(uirf_pkg::PAYLOAD_START)) &&
               (reject == uirf_pkg::RSN_OK) && (pay_left != 16'd0);
    if (emit_pay) begin
      pay_left_next = pay_left - 16'd1;
    end

    pos_next = (pos != POS_MAX) ? pos + POS_W'(1) : pos;

    // a frame that ends before its last header byte is short, whatever else
    why = reject_next;
    if (pos < POS_W'(uirf_pkg::PAYLOAD_START - 1)) begin
      why = uirf_pkg::RSN_SHORT;
    end

    r_pay             = '0;
    r_pay.kind        = uirf_pkg::KIND_PAYLOAD;
    r_pay.data_byte   = s_byte;
    r_pay.reason      = uirf_pkg::RSN_OK;
    r_pay.last        = !s_last;

    r_sum             = '0;
    r_sum.kind        = uirf_pkg::KIND_SUMMARY;
    r_sum.reason      = why;
    r_sum.last        = 1'b1;
    if (why == uirf_pkg::RSN_OK) begin
      r_sum.accepted    = 1'b1;
      r_sum.src_ip      = src_addr_next;
      r_sum.udp_sport   = sport_seen_next;
      r_sum.payload_len = scratch_next;
    end

    slot0  = emit_pay ? r_pay : r_sum;
    slot1  = r_sum;
    push_n = 2'({1'b0, emit_pay} + {1'b0, s_last});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      reject     <= uirf_pkg::RSN_OK;
      src_addr   <= 32'd0;
      sport_seen <= 16'd0;
      scratch    <= 16'd0;
      pay_left   <= 16'd0;
    end else if (fire) begin
      if (s_last) begin
        pos        <= '0;
        reject     <= uirf_pkg::RSN_OK;
        src_addr   <= 32'd0;
        sport_seen <= 16'd0;
        scratch    <= 16'd0;
        pay_left   <= 16'd0;
      end else begin
        pos        <= pos_next;
        reject     <= reject_next;
        src_addr   <= src_addr_next;
        sport_seen <= sport_seen_next;
        scratch    <= scratch_next;
        pay_left   <= pay_left_next;
      end
    end
  end

  // result queue
  always_comb begin
    q_count_next = q_count;
    if (fire) begin
      q_count_next = q_count_next + uirf_pkg::QCNT_W'(push_n);
    end
    if (pop) begin
      q_count_next = q_count_next - uirf_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_head  <= '0;
      q_tail  <= '0;
      q_count <= '0;
    end else begin
      q_count <= q_count_next;
      if (pop) begin
        q_head <= q_head + uirf_pkg::QPTR_W'(1);
      end
      if (fire) begin
        q_tail <= q_tail + uirf_pkg::QPTR_W'(push_n);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && push_n != 2'd0) begin
      q_mem[q_tail] <= slot0;
    end
    if (fire && push_n == 2'd2) begin
      q_mem[q_tail + uirf_pkg::QPTR_W'(1)] <= slot1;
    end
  end

  assign head         = q_mem[q_head];
  assign result_valid = (q_count != '0);
  assign kind         = head.kind;
  assign data_byte    = head.data_byte;
  assign accepted     = head.accepted;
  assign reason       = head.reason;
  assign src_ip       = head.src_ip;
  assign udp_sport    = head.udp_sport;
  assign payload_len  = head.payload_len;
  assign last         = head.last;

  // payload item on offer
  assign head_pay = result_valid && (kind == uirf_pkg::KIND_PAYLOAD);

  `ASSERT_SAME(a_q_bound, clk, rst, 1'b1, q_count <= uirf_pkg::QCNT_W'(uirf_pkg::QDEPTH))
  `ASSERT_NEXT(a_frame_clear, clk, rst, fire && s_last, pos == '0 && pay_left == 16'd0)
  `ASSERT_SAME(a_pay_clean, clk, rst, head_pay, !accepted && reason == uirf_pkg::RSN_OK)

endmodule

`default_nettype wire
